>>> hdl/mtsd_pkg.sv
// Package for the modulated tape sensor detector: item structs, register
// indexes, reset values and arithmetic constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtsd_pkg;

	localparam int FIELD_BITS = 10;
	localparam int LEVEL_BITS = 16;
	localparam int NUM_REGS   = 8;
	localparam int NUM_SENSORS = 4;
	localparam int REG_IDX_BITS = 3;

	// scaled = 10 * (sample - ambient) - 2000, modulo 2^16
	localparam logic [LEVEL_BITS-1:0] SCALE_OFFSET = 16'd2000;

	// floor(x / 5) == (x * 52429) >> 18 for every x below 81920
	localparam logic [15:0] RECIP_5     = 16'd52429;
	localparam int          RECIP_SHIFT = 18;

	localparam logic FUNC_RESTART = 1'b0;
	localparam logic FUNC_TICK    = 1'b1;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_TOP_ON     = 3'd0,
		REG_LEFT_ON    = 3'd1,
		REG_RIGHT_ON   = 3'd2,
		REG_CORNER_ON  = 3'd3,
		REG_TOP_OFF    = 3'd4,
		REG_LEFT_OFF   = 3'd5,
		REG_RIGHT_OFF  = 3'd6,
		REG_CORNER_OFF = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		SENSOR_NONE   = 3'd0,
		SENSOR_TOP    = 3'd1,
		SENSOR_LEFT   = 3'd2,
		SENSOR_RIGHT  = 3'd3,
		SENSOR_CORNER = 3'd4
	} sensor_code_t;

	localparam logic [LEVEL_BITS-1:0] REG_RESET [NUM_REGS] = '{
		16'd1080, 16'd1050, 16'd1000, 16'd500,
		16'd1110, 16'd1110, 16'd1110, 16'd700
	};

	typedef struct packed {
		logic                  func;
		logic [FIELD_BITS-1:0] top_sample;
		logic [FIELD_BITS-1:0] left_sample;
		logic [FIELD_BITS-1:0] right_sample;
		logic [FIELD_BITS-1:0] corner_sample;
	} in_item_t;

	typedef struct packed {
		logic       emitter_level;
		logic       event_valid;
		logic       tape_present;
		logic [2:0] which_sensor;
	} out_item_t;

endpackage

`default_nettype wire

>>> hdl/modulated_tape_sensor_detector_core.sv
// Modulated tape sensor detector core.
// Flow: an accepted item enters the input register, and its result is loaded into the
// output register as soon as that register is not stalled full.
// Throughput: one item per cycle while the output is not stalled; the input register
// and output register are the only stages, so a stall on the output holds at most
// two items inside, one in each. Reset (arst_n low): levels to defaults; ambient,
// phase, tape state, emitter and both stages clear. Latched samples are not reset.
`timescale 1ns / 1ps
`default_nettype none

module modulated_tape_sensor_detector_core
	import mtsd_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int SUM_BITS  = SAMPLE_BITS + 3;
	localparam int PROD_BITS = SUM_BITS + 16;

	// configuration registers
	logic [LEVEL_BITS-1:0] level_q [NUM_REGS];
	logic [REG_IDX_BITS-1:0] reg_idx;

	assign reg_idx = paddr[4:2];
	assign pready  = 1'b1;
	assign prdata  = {16'b0, level_q[reg_idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) level_q[i] <= REG_RESET[i];
		end else if (psel && penable && pwrite && pready) begin
			level_q[reg_idx] <= pwdata[LEVEL_BITS-1:0];
		end
	end

	// pipeline control
	logic     valid_s1;
	in_item_t item_s1;
	logic     adv_s1;
	logic     out_valid_q;
	out_item_t out_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_s1 <= in_data;
	end

	// block state
	logic [SAMPLE_BITS-1:0] ambient_q;
	logic [SAMPLE_BITS-1:0] stored_q [NUM_SENSORS];
	logic                   phase_q;
	logic                   tape_q;
	logic                   emitter_q;

	logic [SAMPLE_BITS-1:0] s [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] below_on;
	logic [NUM_SENSORS-1:0] above_off;

	assign s[0] = SAMPLE_BITS'(item_s1.top_sample);
	assign s[1] = SAMPLE_BITS'(item_s1.left_sample);
	assign s[2] = SAMPLE_BITS'(item_s1.right_sample);
	assign s[3] = SAMPLE_BITS'(item_s1.corner_sample);

	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_chan
		mtsd_scale #(.SAMPLE_BITS(SAMPLE_BITS)) u_scale (
			.sample    (s[g]),
			.ambient   (ambient_q),
			.on_level  (level_q[g]),
			.off_level (level_q[g + NUM_SENSORS]),
			.below_on  (below_on[g]),
			.above_off (above_off[g])
		);
	end

	logic [SUM_BITS-1:0]    sum;
	logic [PROD_BITS-1:0]   prod;
	logic [SAMPLE_BITS-1:0] ambient_next;
	logic                   tape_next;
	logic                   change;
	sensor_code_t           code;
	out_item_t              result;

	always_comb begin
		sum = SUM_BITS'(ambient_q) + SUM_BITS'(s[0]) + SUM_BITS'(s[1])
			+ SUM_BITS'(s[2]) + SUM_BITS'(s[3]);
		// divide by five through the reciprocal
		prod = PROD_BITS'(sum) * PROD_BITS'(RECIP_5);
		ambient_next = SAMPLE_BITS'(prod >> RECIP_SHIFT);

		if (|below_on) tape_next = 1'b1;
		else if (|above_off) tape_next = 1'b0;
		else tape_next = tape_q;

		// first latched sample below its detect level
		if (LEVEL_BITS'(stored_q[0]) < level_q[REG_TOP_ON]) code = SENSOR_TOP;
		else if (LEVEL_BITS'(stored_q[1]) < level_q[REG_LEFT_ON]) code = SENSOR_LEFT;
		else if (LEVEL_BITS'(stored_q[2]) < level_q[REG_RIGHT_ON]) code = SENSOR_RIGHT;
		else if (LEVEL_BITS'(stored_q[3]) < level_q[REG_CORNER_ON]) code = SENSOR_CORNER;
		else code = SENSOR_NONE;

		change = (item_s1.func == FUNC_TICK) && phase_q && (tape_next != tape_q);

		result.event_valid  = change;
		result.which_sensor = change ? code : SENSOR_NONE;
		if (item_s1.func == FUNC_RESTART) begin
			result.emitter_level = emitter_q;
			result.tape_present  = tape_q;
		end else if (!phase_q) begin
			result.emitter_level = 1'b0;
			result.tape_present  = tape_q;
		end else begin
			result.emitter_level = 1'b1;
			result.tape_present  = tape_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambient_q <= '0;
			phase_q   <= 1'b0;
			tape_q    <= 1'b0;
			emitter_q <= 1'b0;
		end else if (adv_s1 && item_s1.func == FUNC_TICK) begin
			phase_q   <= !phase_q;
			emitter_q <= phase_q;
			if (!phase_q) ambient_q <= ambient_next;
			else tape_q <= tape_next;
		end
	end

	// latch samples on a storing tick
	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.func == FUNC_TICK && !phase_q) begin
			for (int i = 0; i < NUM_SENSORS; i++) stored_q[i] <= s[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) out_q <= result;
	end

	// checks
	a_event_on_measure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_valid |-> out_data.emitter_level)
		else $error("event reported outside a measuring tick");

	a_code_needs_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.which_sensor != SENSOR_NONE |-> out_data.event_valid)
		else $error("sensor code without an event");

	a_tape_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid && out_data.tape_present == tape_q)
		else $error("reported tape state differs from held state");

	a_phase_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && item_s1.func == FUNC_TICK |=> phase_q != $past(phase_q))
		else $error("phase did not advance on a tick");

endmodule

`default_nettype wire

>>> hdl/mtsd_scale.sv
// One sensor channel: scales a measured sample against the ambient level
// and compares it with the detect and release levels. Uses mtsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtsd_scale
	import mtsd_pkg::*;
#(
	parameter int SAMPLE_BITS = 10
) (
	input  wire logic [SAMPLE_BITS-1:0] sample,
	input  wire logic [SAMPLE_BITS-1:0] ambient,
	input  wire logic [LEVEL_BITS-1:0]  on_level,
	input  wire logic [LEVEL_BITS-1:0]  off_level,
	output logic                        below_on,
	output logic                        above_off
);

	logic [LEVEL_BITS-1:0] diff;
	logic [LEVEL_BITS-1:0] scaled;

	always_comb begin
		diff   = LEVEL_BITS'(sample) - LEVEL_BITS'(ambient);
		// times ten as 8x + 2x, all wrapping at 16 bits
		scaled = (diff << 3) + (diff << 1) - SCALE_OFFSET;
		below_on  = scaled < on_level;
		above_off = scaled > off_level;
	end

endmodule

`default_nettype wire

>>> verif/modulated_tape_sensor_detector_core_test.sv
// Self-checking bench for modulated_tape_sensor_detector_core: directed rows against
// fixed expected results, then phased random ticks under several level settings,
// checked against a local model. Depends on mtsd_pkg and the core RTL only.
`timescale 1ns / 1ps

module modulated_tape_sensor_detector_core_test;
	import mtsd_pkg::*;

	localparam int ITEMS_PER_PHASE = 160;
	localparam int NUM_PHASES      = 10;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 6;
	localparam int SCALE_GAIN      = 10;
	localparam int AMBIENT_DIV     = 5;
	// limit allows for ~1650 items plus hold-offs and level writes
	localparam int RUN_LIMIT_NS    = 5_000_000;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t fixed;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// detector model state
	logic [15:0]            level_reg [NUM_REGS];
	logic [FIELD_BITS-1:0]  amb_est = '0;
	logic [FIELD_BITS-1:0]  latched [NUM_SENSORS];
	bit                     measure_phase = 1'b0;
	bit                     tape_seen = 1'b0;
	bit                     emit_on = 1'b0;

	out_item_t   reports [$];
	script_row_t script [$];
	int          fault_count = 0;
	bit          tx_pace = 1'b0;
	bit          rx_pace = 1'b0;
	int          squeeze_req = 0;

	modulated_tape_sensor_detector_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("FAIL modulated_tape_sensor_detector_core");
		$finish;
	end

	function automatic void predict_detect(input in_item_t it, output out_item_t r);
		logic [FIELD_BITS-1:0] s [NUM_SENSORS];
		logic [15:0] diff;
		logic [15:0] scaled;
		int sum;
		bit any_on;
		bit any_off;
		bit next_tape;
		s = '{it.top_sample, it.left_sample, it.right_sample, it.corner_sample};
		r = '0;
		next_tape = tape_seen;
		any_on = 1'b0;
		any_off = 1'b0;
		if (it.func == FUNC_TICK) begin
			if (!measure_phase) begin
				sum = int'(amb_est);
				for (int i = 0; i < NUM_SENSORS; i++) begin
					latched[i] = s[i];
					sum += int'(s[i]);
				end
				amb_est = FIELD_BITS'(sum / AMBIENT_DIV);
				emit_on = 1'b0;
				measure_phase = 1'b1;
			end else begin
				emit_on = 1'b1;
				for (int i = 0; i < NUM_SENSORS; i++) begin
					diff = 16'(s[i]) - 16'(amb_est);
					scaled = diff * 16'(SCALE_GAIN) - SCALE_OFFSET;
					if (scaled < level_reg[REG_TOP_ON + i])
						any_on = 1'b1;
					if (scaled > level_reg[REG_TOP_OFF + i])
						any_off = 1'b1;
				end
				if (any_on)
					next_tape = 1'b1;
				else if (any_off)
					next_tape = 1'b0;
				measure_phase = 1'b0;
				if (next_tape != tape_seen) begin
					r.event_valid = 1'b1;
					// first latched sample under its detect level names the sensor
					for (int i = 0; i < NUM_SENSORS; i++) begin
						if (r.which_sensor == SENSOR_NONE &&
								latched[i] < level_reg[REG_TOP_ON + i])
							r.which_sensor = 3'(SENSOR_TOP + i);
					end
					tape_seen = next_tape;
				end
			end
		end
		r.emitter_level = emit_on;
		r.tape_present = tape_seen;
	endfunction

	// Storing ticks cluster around a base; measuring ticks aim each sensor near
	// one of its levels so the hysteresis band and both crossings get hit.
	function automatic in_item_t gen_tick();
		in_item_t it;
		logic [FIELD_BITS-1:0] s [NUM_SENSORS];
		int roll;
		int base;
		int t;
		roll = int'($urandom_range(0, 99));
		base = int'($urandom_range(0, 1023));
		it.func = (roll < 8) ? FUNC_RESTART : FUNC_TICK;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (roll < 20 || $urandom_range(0, 4) == 0) begin
				s[i] = FIELD_BITS'($urandom);
			end else if (!measure_phase) begin
				s[i] = FIELD_BITS'(base + int'($urandom_range(0, 40)) - 20);
			end else begin
				t = int'(level_reg[$urandom_range(0, 1) ? REG_TOP_ON + i : REG_TOP_OFF + i]);
				t = t + int'($urandom_range(0, 60)) - 30;
				if (t > 32767)
					t -= 65536;
				s[i] = FIELD_BITS'(int'(amb_est) + (t + int'(SCALE_OFFSET)) / SCALE_GAIN);
			end
		end
		it.top_sample = s[0];
		it.left_sample = s[1];
		it.right_sample = s[2];
		it.corner_sample = s[3];
		return it;
	endfunction

	function automatic void add_row(input logic fn, input logic [FIELD_BITS-1:0] t, l, r, c,
			input bit typed, input logic em, ev, tp, input sensor_code_t w);
		script_row_t row;
		row.item = '{func: fn, top_sample: t, left_sample: l, right_sample: r,
			corner_sample: c};
		row.typed = typed;
		row.fixed = '{emitter_level: em, event_valid: ev, tape_present: tp,
			which_sensor: w};
		script.push_back(row);
	endfunction

	task automatic send_item(input in_item_t it, input bit typed, input out_item_t fixed);
		int gap;
		out_item_t res;
		gap = tx_pace ? int'($urandom_range(0, 14)) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_detect(it, res);
		reports.push_back(typed ? fixed : res);
	endtask

	task automatic write_level(input reg_idx_t idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		level_reg[idx] = val;
		// read back straight after the write
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== val) begin
			$error("prdata[%s] expected %0d got %0d", idx.name(), val, prdata[15:0]);
			fault_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_report(input out_item_t got);
		out_item_t want;
		if (reports.size() == 0) begin
			$error("result with nothing pending: %p", got);
			fault_count++;
			return;
		end
		want = reports.pop_front();
		if (got.emitter_level !== want.emitter_level) begin
			$error("emitter_level expected %0d got %0d", want.emitter_level, got.emitter_level);
			fault_count++;
		end
		if (got.event_valid !== want.event_valid) begin
			$error("event_valid expected %0d got %0d", want.event_valid, got.event_valid);
			fault_count++;
		end
		if (got.tape_present !== want.tape_present) begin
			$error("tape_present expected %0d got %0d", want.tape_present, got.tape_present);
			fault_count++;
		end
		if (got.which_sensor !== want.which_sensor) begin
			$error("which_sensor expected %0d got %0d", want.which_sensor, got.which_sensor);
			fault_count++;
		end
	endtask

	initial begin : result_sink
		int gap;
		int squeeze_seen;
		squeeze_seen = 0;
		@(posedge arst_n);
		forever begin
			gap = rx_pace ? int'($urandom_range(0, 14)) : 0;
			if (squeeze_req != squeeze_seen) begin
				squeeze_seen = squeeze_req;
				gap = HOLD_OFF_CYCLES;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			check_report(out_data);
		end
	end

	initial begin : stimulus
		logic [15:0] on_lvl [NUM_SENSORS];
		logic [15:0] val;
		for (int k = 0; k < NUM_REGS; k++)
			level_reg[k] = REG_RESET[k];

		// hand-checked sequence from reset levels
		add_row(FUNC_RESTART, 1023, 1023, 1023, 1023, 1, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 0, 0, 0, 0, 1, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 1023, 1023, 1023, 1023, 1, 1, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 1023, 1023, 1023, 1023, 1, 0, 0, 0, SENSOR_NONE);
		// sample under ambient wraps to a large scaled value
		add_row(FUNC_TICK, 0, 0, 0, 0, 1, 1, 0, 0, SENSOR_NONE);
		add_row(FUNC_RESTART, 1023, 1023, 1023, 1023, 1, 1, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 0, 0, 0, 0, 1, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 463, 1023, 1023, 1023, 1, 1, 1, 1, SENSOR_TOP);
		add_row(FUNC_RESTART, 0, 0, 0, 0, 1, 1, 0, 1, SENSOR_NONE);
		add_row(FUNC_TICK, 300, 300, 300, 300, 1, 0, 0, 1, SENSOR_NONE);
		// every sensor inside its hysteresis band: hold state
		add_row(FUNC_TICK, 582, 582, 582, 542, 1, 1, 0, 1, SENSOR_NONE);
		add_row(FUNC_TICK, 300, 300, 300, 300, 1, 0, 0, 1, SENSOR_NONE);
		add_row(FUNC_TICK, 1023, 1023, 1023, 1023, 1, 1, 1, 0, SENSOR_TOP);
		add_row(FUNC_TICK, 1023, 1023, 1023, 0, 1, 0, 0, 0, SENSOR_NONE);
		// corner alone detects
		add_row(FUNC_TICK, 1023, 1023, 1023, 912, 1, 1, 1, 1, SENSOR_TOP);
		add_row(FUNC_RESTART, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 1, 1, 0, 1, SENSOR_NONE);
		add_row(FUNC_TICK, 10'h2AA, 10'h155, 10'h2AA, 10'h155, 0, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_RESTART, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 0, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 10'h155, 10'h2AA, 10'h155, 10'h2AA, 0, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 0, 1023, 0, 1023, 0, 0, 0, 0, SENSOR_NONE);
		add_row(FUNC_TICK, 1023, 0, 1023, 0, 0, 0, 0, 0, SENSOR_NONE);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_pace = 1'b1;
		foreach (script[k])
			send_item(script[k].item, script[k].typed, script[k].fixed);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			for (int i = 0; i < NUM_SENSORS; i++)
				on_lvl[i] = 16'($urandom_range(0, 1200));
			for (int k = 0; k < NUM_REGS; k++) begin
				case (ph)
					0: val = 16'h0000;
					1: val = 16'hFFFF;
					2: val = (k < NUM_SENSORS) ? 16'hFFFF : 16'h0000;
					3: val = (k < NUM_SENSORS) ? 16'h0000 : 16'hFFFF;
					4: val = REG_RESET[k];
					9: val = 16'($urandom);
					default: val = (k < NUM_SENSORS) ? on_lvl[k] :
						on_lvl[k - NUM_SENSORS] + 16'($urandom_range(0, 300));
				endcase
				write_level(reg_idx_t'(k), val);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 40 == 0) begin
					tx_pace = 1'($urandom_range(0, 1));
					rx_pace = 1'($urandom_range(0, 1));
				end
				// long receiver hold-off with the sender pushing back to back
				if ((ph == 4 && n == 20) || (ph == 7 && n == 80)) begin
					squeeze_req++;
					tx_pace = 1'b0;
				end
				send_item(gen_tick(), 1'b0, '0);
			end
		end

		settle();
		if (fault_count == 0)
			$display("PASS modulated_tape_sensor_detector_core");
		else
			$display("FAIL modulated_tape_sensor_detector_core");
		$finish;
	end

endmodule

>>> modulated_tape_sensor_detector_core.f
hdl/mtsd_pkg.sv
hdl/mtsd_scale.sv
hdl/modulated_tape_sensor_detector_core.sv
verif/modulated_tape_sensor_detector_core_test.sv
